FILE: src/bcc_pkg.sv
// ----------------------------------------------------------------------------
// Buffer cache package
// Shared sizes, operation codes, datapath actions and controller status.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bcc_pkg;

   localparam int ENTRIES  = 64;
   localparam int IDX_W    = $clog2(ENTRIES);
   localparam int PIN_BITS = 6;
   localparam int SECTOR_W = 32;

   localparam logic [IDX_W-1:0]    IDX_LAST = IDX_W'(ENTRIES - 1);
   localparam logic [PIN_BITS-1:0] PIN_MAX  = '1;

   localparam logic [2:0] COST_DIRTY    = 3'd2;
   localparam logic [2:0] COST_ACCESSED = 3'd4;
   localparam logic [3:0] COST_LIMIT    = 4'd8;

   localparam logic [1:0] OP_GET     = 2'd0;
   localparam logic [1:0] OP_RELEASE = 2'd1;
   localparam logic [1:0] OP_FLUSH   = 2'd2;
   localparam logic [1:0] OP_SPARE   = 2'd3;

   typedef enum logic [3:0] {
      ACT_NOP,
      ACT_LOAD,
      ACT_RD_IDX,
      ACT_RD_HAND,
      ACT_RD_BEST,
      ACT_RD_ENTRY,
      ACT_H_CHK,
      ACT_S_CHK,
      ACT_V_WR,
      ACT_R_DO,
      ACT_F_CHK,
      ACT_F_END
   } act_type;

   typedef struct packed {
      logic match;
      logic idx_last;
      logic sweep_stop;
      logic have_next;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

FILE: src/bcc_datapath.sv
// ----------------------------------------------------------------------------
// Buffer cache datapath
// Tag and pin memories, entry flags, clock hand, flush holding word and the
// result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bcc_datapath (
   input  wire                   clock,
   input  wire                   reset,
   input  bcc_pkg::act_type      act,
   input  wire  [39:0]           req_tdata,
   output bcc_pkg::status_type   status,
   output logic                  rsp_tvalid,
   input  wire                   rsp_tready,
   output logic [47:0]           rsp_tdata,
   output logic                  rsp_tlast
);

   localparam int IW = bcc_pkg::IDX_W;
   localparam int PW = bcc_pkg::PIN_BITS;
   localparam int SW = bcc_pkg::SECTOR_W;

   logic [SW-1:0] tag_mem [bcc_pkg::ENTRIES];
   logic [PW-1:0] pin_mem [bcc_pkg::ENTRIES];

   logic [SW-1:0] sector_ff;
   logic          zero_ff;
   logic [IW-1:0] entry_ff;
   logic          setd_ff;

   logic [bcc_pkg::ENTRIES-1:0] valid_ff, dirty_ff, acc_ff;
   logic [IW-1:0] idx_ff, hand_ff, start_ff, best_ff;
   logic [3:0]    min_cost_ff;
   logic          have_ff;
   logic [SW-1:0] rd_tag_ff;
   logic [PW-1:0] rd_pin_ff;
   logic          pend_valid_ff;
   logic [IW-1:0] pend_slot_ff;
   logic [SW-1:0] pend_tag_ff;

   logic          rsp_valid_ff;
   logic [IW-1:0] rsp_slot_ff;
   logic          rsp_status_ff, rsp_hit_ff, rsp_wb_ff, rsp_fill_ff, rsp_last_ff;
   logic [SW-1:0] rsp_wbs_ff;

   logic          rd_en;
   logic [IW-1:0] rd_addr;
   logic          match, pin_full, idx_last, out_free;
   logic [PW-1:0] cur_pin, rel_pin;
   logic [2:0]    cost;
   logic          take, found, stop, have_next, rel_ok, f_dirty, wb_old;
   logic [IW-1:0] hand_in;

   logic          emit, e_status, e_hit, e_wb, e_fill, e_last;
   logic [IW-1:0] e_slot;
   logic [SW-1:0] e_wbs;
   logic          pin_we;
   logic [IW-1:0] pin_wa;
   logic [PW-1:0] pin_wd;

   always_comb begin
      rd_en   = 1'b1;
      rd_addr = idx_ff;
      case (act)
         bcc_pkg::ACT_RD_IDX:   rd_addr = idx_ff;
         bcc_pkg::ACT_RD_HAND:  rd_addr = hand_ff;
         bcc_pkg::ACT_RD_BEST:  rd_addr = best_ff;
         bcc_pkg::ACT_RD_ENTRY: rd_addr = entry_ff;
         default:               rd_en   = 1'b0;
      endcase
   end

   assign match     = valid_ff[idx_ff] && (rd_tag_ff == sector_ff);
   assign pin_full  = (rd_pin_ff == bcc_pkg::PIN_MAX);
   assign idx_last  = (idx_ff == bcc_pkg::IDX_LAST);
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign cur_pin   = valid_ff[hand_ff] ? rd_pin_ff : '0;
   assign cost      = (dirty_ff[hand_ff] ? bcc_pkg::COST_DIRTY : 3'd0)
                    + (acc_ff[hand_ff] ? bcc_pkg::COST_ACCESSED : 3'd0);
   assign take      = (cur_pin == '0) && ({1'b0, cost} < min_cost_ff);
   assign found     = take && !acc_ff[hand_ff];
   assign hand_in   = (hand_ff == bcc_pkg::IDX_LAST) ? '0 : hand_ff + IW'(1);
   assign stop      = found || (hand_in == start_ff);
   assign have_next = have_ff || take;
   assign rel_pin   = valid_ff[entry_ff] ? rd_pin_ff : '0;
   assign rel_ok    = (rel_pin != '0);
   assign f_dirty   = valid_ff[idx_ff] && dirty_ff[idx_ff];
   assign wb_old    = valid_ff[best_ff] && dirty_ff[best_ff];

   assign status = '{match: match, idx_last: idx_last, sweep_stop: stop,
                     have_next: have_next, out_free: out_free};

   always_comb begin
      emit     = 1'b0;
      e_slot   = '0;
      e_status = 1'b0;
      e_hit    = 1'b0;
      e_wb     = 1'b0;
      e_wbs    = '0;
      e_fill   = 1'b0;
      e_last   = 1'b0;
      pin_we   = 1'b0;
      pin_wa   = idx_ff;
      pin_wd   = rd_pin_ff + PW'(1);
      case (act)
         bcc_pkg::ACT_H_CHK: begin
            if (match) begin
               emit     = 1'b1;
               e_slot   = idx_ff;
               e_status = pin_full;
               e_hit    = 1'b1;
               e_last   = 1'b1;
               pin_we   = !pin_full;
            end
         end
         bcc_pkg::ACT_S_CHK: begin
            if (stop && !have_next) begin
               emit     = 1'b1;
               e_status = 1'b1;
               e_last   = 1'b1;
            end
         end
         bcc_pkg::ACT_V_WR: begin
            emit   = 1'b1;
            e_slot = best_ff;
            e_wb   = wb_old;
            e_wbs  = wb_old ? rd_tag_ff : '0;
            e_fill = !zero_ff;
            e_last = 1'b1;
            pin_we = 1'b1;
            pin_wa = best_ff;
            pin_wd = PW'(1);
         end
         bcc_pkg::ACT_R_DO: begin
            pin_we = rel_ok;
            pin_wa = entry_ff;
            pin_wd = rel_pin - PW'(1);
         end
         bcc_pkg::ACT_F_CHK: begin
            if (f_dirty && pend_valid_ff) begin
               emit   = 1'b1;
               e_slot = pend_slot_ff;
               e_wb   = 1'b1;
               e_wbs  = pend_tag_ff;
            end
         end
         bcc_pkg::ACT_F_END: begin
            emit   = 1'b1;
            e_last = 1'b1;
            if (pend_valid_ff) begin
               e_slot = pend_slot_ff;
               e_wb   = 1'b1;
               e_wbs  = pend_tag_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         dirty_ff      <= '0;
         acc_ff        <= '0;
         idx_ff        <= '0;
         hand_ff       <= '0;
         min_cost_ff   <= bcc_pkg::COST_LIMIT;
         have_ff       <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (act)
            bcc_pkg::ACT_LOAD: begin
               idx_ff        <= '0;
               pend_valid_ff <= 1'b0;
            end
            bcc_pkg::ACT_H_CHK: begin
               if (match) begin
                  if (!pin_full) begin
                     acc_ff[idx_ff] <= 1'b1;
                  end
               end else if (idx_last) begin
                  have_ff     <= 1'b0;
                  min_cost_ff <= bcc_pkg::COST_LIMIT;
               end else begin
                  idx_ff <= idx_ff + IW'(1);
               end
            end
            bcc_pkg::ACT_S_CHK: begin
               if (take) begin
                  have_ff     <= 1'b1;
                  min_cost_ff <= {1'b0, cost};
               end else begin
                  acc_ff[hand_ff] <= 1'b0;
               end
               hand_ff <= hand_in;
            end
            bcc_pkg::ACT_V_WR: begin
               valid_ff[best_ff] <= 1'b1;
               dirty_ff[best_ff] <= 1'b0;
               acc_ff[best_ff]   <= 1'b1;
            end
            bcc_pkg::ACT_R_DO: begin
               if (rel_ok && setd_ff) begin
                  dirty_ff[entry_ff] <= 1'b1;
               end
            end
            bcc_pkg::ACT_F_CHK: begin
               if (f_dirty) begin
                  dirty_ff[idx_ff] <= 1'b0;
                  pend_valid_ff    <= 1'b1;
               end
               idx_ff <= idx_ff + IW'(1);
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (act == bcc_pkg::ACT_LOAD) begin
         sector_ff <= req_tdata[31:0];
         zero_ff   <= req_tdata[32];
         entry_ff  <= req_tdata[38:33];
         setd_ff   <= req_tdata[39];
      end
      if (act == bcc_pkg::ACT_H_CHK && !match && idx_last) begin
         start_ff <= hand_ff;
      end
      if (act == bcc_pkg::ACT_S_CHK && take) begin
         best_ff <= hand_ff;
      end
      if (act == bcc_pkg::ACT_F_CHK && f_dirty) begin
         pend_slot_ff <= idx_ff;
         pend_tag_ff  <= rd_tag_ff;
      end
      if (rd_en) begin
         rd_tag_ff <= tag_mem[rd_addr];
         rd_pin_ff <= pin_mem[rd_addr];
      end
      if (act == bcc_pkg::ACT_V_WR) begin
         tag_mem[best_ff] <= sector_ff;
      end
      if (pin_we) begin
         pin_mem[pin_wa] <= pin_wd;
      end
      if (emit) begin
         rsp_slot_ff   <= e_slot;
         rsp_status_ff <= e_status;
         rsp_hit_ff    <= e_hit;
         rsp_wb_ff     <= e_wb;
         rsp_wbs_ff    <= e_wbs;
         rsp_fill_ff   <= e_fill;
         rsp_last_ff   <= e_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {6'b0, rsp_fill_ff, rsp_wbs_ff, rsp_wb_ff, rsp_hit_ff,
                        rsp_status_ff, rsp_slot_ff};

   // A new word is only loaded when the result register is free.
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      emit |-> out_free)
      else $error("result word overwritten");

   // A victim fill leaves its entry valid.
   a_fill_valid: assert property (@(posedge clock) disable iff (reset)
      (act == bcc_pkg::ACT_V_WR) |=> valid_ff[best_ff])
      else $error("filled entry not valid");

   // A sweep that finds no victim ends with the hand back at its start.
   a_sweep_wrap: assert property (@(posedge clock) disable iff (reset)
      (act == bcc_pkg::ACT_S_CHK && stop && !have_next) |=> (hand_ff == start_ff))
      else $error("clock hand not back at start");

endmodule

`default_nettype wire

FILE: src/bcc_controller.sv
// ----------------------------------------------------------------------------
// Buffer cache controller
// Sequences lookup, clock sweep, victim fill, release and flush.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bcc_controller (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_tvalid,
   output logic                 req_tready,
   input  wire  [1:0]           req_tuser,
   input  bcc_pkg::status_type  status,
   output bcc_pkg::act_type     act
);

   typedef enum logic [3:0] {
      S_IDLE, S_H_RD, S_H_CHK, S_S_RD, S_S_CHK, S_V_RD, S_V_WR,
      S_R_RD, S_R_DO, S_F_RD, S_F_CHK, S_F_END
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff;

   always_comb begin
      state_in = state_ff;
      act      = bcc_pkg::ACT_NOP;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid && ready_ff) begin
               act = bcc_pkg::ACT_LOAD;
               case (req_tuser)
                  bcc_pkg::OP_GET:     state_in = S_H_RD;
                  bcc_pkg::OP_RELEASE: state_in = S_R_RD;
                  bcc_pkg::OP_FLUSH:   state_in = S_F_RD;
                  default:             state_in = S_IDLE;
               endcase
            end
         end
         S_H_RD: begin
            act      = bcc_pkg::ACT_RD_IDX;
            state_in = S_H_CHK;
         end
         S_H_CHK: begin
            if (status.out_free) begin
               act = bcc_pkg::ACT_H_CHK;
               if (status.match) begin
                  state_in = S_IDLE;
               end else if (status.idx_last) begin
                  state_in = S_S_RD;
               end else begin
                  state_in = S_H_RD;
               end
            end
         end
         S_S_RD: begin
            act      = bcc_pkg::ACT_RD_HAND;
            state_in = S_S_CHK;
         end
         S_S_CHK: begin
            if (status.out_free) begin
               act = bcc_pkg::ACT_S_CHK;
               if (!status.sweep_stop) begin
                  state_in = S_S_RD;
               end else if (status.have_next) begin
                  state_in = S_V_RD;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_V_RD: begin
            act      = bcc_pkg::ACT_RD_BEST;
            state_in = S_V_WR;
         end
         S_V_WR: begin
            if (status.out_free) begin
               act      = bcc_pkg::ACT_V_WR;
               state_in = S_IDLE;
            end
         end
         S_R_RD: begin
            act      = bcc_pkg::ACT_RD_ENTRY;
            state_in = S_R_DO;
         end
         S_R_DO: begin
            act      = bcc_pkg::ACT_R_DO;
            state_in = S_IDLE;
         end
         S_F_RD: begin
            act      = bcc_pkg::ACT_RD_IDX;
            state_in = S_F_CHK;
         end
         S_F_CHK: begin
            if (status.out_free) begin
               act      = bcc_pkg::ACT_F_CHK;
               state_in = status.idx_last ? S_F_END : S_F_RD;
            end
         end
         S_F_END: begin
            if (status.out_free) begin
               act      = bcc_pkg::ACT_F_END;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         ready_ff <= (state_in == S_IDLE);
      end
   end

   assign req_tready = ready_ff;

   // A word is only taken while the controller is idle.
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      ready_ff |-> (state_ff == S_IDLE))
      else $error("ready outside idle");

   // A taken get, release or flush drops ready on the following cycle.
   a_busy_after: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser != bcc_pkg::OP_SPARE) |=> !req_tready)
      else $error("ready held after a word was taken");

   // A release is back in idle in the cycle after its pin update state.
   a_release_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_R_DO) |=> (state_ff == S_IDLE))
      else $error("release did not finish");

endmodule

`default_nettype wire

FILE: src/buffer_cache_clock_replacement.sv
// ----------------------------------------------------------------------------
// Buffer cache clock replacement
// Tag and second-chance replacement controller for a sector buffer cache.
// ----------------------------------------------------------------------------
// Channel  Ports   tdata fields (low bit up)                          tuser / tlast
// request  req_*   sector[31:0] zero_fill entry[5:0] set_dirty          op[1:0] / -
// result   rsp_*   slot[5:0] status hit writeback writeback_sector fill_read
//                                                                         - / last
// A get checks the tags in turn; on a miss it sweeps the clock hand and fills the chosen
// victim. A release reads the entry, then updates its pin; a flush walks every entry.
// Each check works on a registered read of the tag and pin memories.
// Reset is synchronous and clears the entry flags and the clock hand; the tag and pin memories are not cleared.
// A stalled result holds the sequencer before each step that emits a word; a new word is taken while a result waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module buffer_cache_clock_replacement (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [39:0] req_tdata,   // sector, zero_fill, entry, set_dirty
   input  wire  [1:0]  req_tuser,   // op
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [47:0] rsp_tdata,   // slot, status, hit, writeback, writeback_sector, fill_read
   output logic        rsp_tlast
);

   bcc_pkg::act_type    act;
   bcc_pkg::status_type status;

   bcc_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .status     (status),
      .act        (act)
   );

   bcc_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .act        (act),
      .req_tdata  (req_tdata),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire
